[rtl/core/cossim_pkg.sv]
// Package for the cosine similarity block: types, widths and constants.
`timescale 1ns / 1ps
`default_nettype none
package cossim_pkg;

    // field and accumulator widths
    localparam int ElemW     = 16;
    localparam int AccW      = 48;
    localparam int FracBits  = 15;
    localparam int RootW     = AccW / 2;
    localparam int MulW      = RootW + 1;
    localparam int ProdW     = 2 * MulW;
    localparam int SumW      = ProdW;
    localparam int RemW      = 64;
    localparam int QuoW      = 17;
    localparam int CntW      = 5;
    localparam int CosW      = 16;

    // last iteration indices of the shared compare-subtract unit
    localparam logic [CntW-1:0] SqrtLast = CntW'(RootW - 1);
    localparam logic [CntW-1:0] DivLast  = CntW'(QuoW - 1);

    // saturation bounds
    localparam logic signed [SumW-1:0] DotMax  = SumW'((64'sd1 <<< (AccW - 1)) - 64'sd1);
    localparam logic signed [SumW-1:0] DotMin  = -SumW'(64'sd1 <<< (AccW - 1));
    localparam logic signed [SumW-1:0] NormMax = SumW'((64'sd1 <<< AccW) - 64'sd1);
    localparam logic signed [CosW-1:0] CosMax  = 16'sh7FFF;
    localparam logic signed [CosW-1:0] CosMin  = 16'sh8000;
    localparam logic [QuoW-1:0]        QPosLim = QuoW'(32767);
    localparam logic [QuoW-1:0]        QNegLim = QuoW'(32768);

    // first root bit of the square root: highest power of four below 2^48
    localparam logic [AccW-1:0] SqrtBit0 = AccW'(1) << (AccW - 2);

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_AB,
        S_MUL_AA,
        S_MUL_BB,
        S_ACC_BB,
        S_SQRT_A,
        S_SQRT_B,
        S_MUL_DEN,
        S_DIV_INIT,
        S_DIV,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

[rtl/core/cosine_similarity.sv]
// Top level of the cosine similarity block: sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Each element pair is accepted only in S_IDLE and then passes S_MUL_AB, S_MUL_AA,
// S_MUL_BB and S_ACC_BB: one shared 25x25 multiplier forms a*b, a*a and b*b in turn.
// A last pair adds 24 + 24 root steps, a multiply, a range check and 17 divide steps
// (skipped on a zero norm) on the shared 64-bit compare-subtract unit; a stall holds its result.
// Reset (synchronous, active low) clears the sums, the sequencer and o_m_tvalid.
module cosine_similarity (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,  // [15:0] elem_a, [31:16] elem_b
    input  wire logic        i_s_tlast,  // last_elem
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,  // [15:0] cosine
    output logic             o_m_tuser   // [0] zero_norm
);
    import cossim_pkg::*;

    t_state r_state, n_state;

    // captured beat
    logic signed [ElemW-1:0] r_a, r_b;
    logic                    r_last;

    // accumulators
    logic signed [AccW-1:0] r_dot;
    logic [AccW-1:0]        r_norm_a, r_norm_b;

    // shared multiplier
    logic signed [MulW-1:0]  w_mul_x, w_mul_y;
    logic signed [ProdW-1:0] r_prod;

    // root and divide registers
    logic [RemW-1:0]    r_rem, r_dsh;
    logic [AccW-1:0]    r_root, r_bit;
    logic [RootW-1:0]   r_ra;
    logic [QuoW-1:0]    r_q;
    logic [CntW-1:0]    r_cnt;
    logic               r_neg, r_zero, r_ovf;

    // output register
    logic               r_out_valid;
    logic [CosW-1:0]    r_out_cos;
    logic               r_out_zero;

    // compare-subtract operands
    logic [RemW-1:0]    w_cs_a, w_cs_b, w_cs_diff;
    logic               w_cs_ge;

    logic               w_in_acc, w_out_free;
    logic signed [SumW-1:0] w_dot_sum, w_norm_sum, w_norm_old;
    logic [AccW-1:0]    w_root_next, w_mag, w_den;
    logic [CosW-1:0]    w_cos;

    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    // dot magnitude and denominator for the divider setup
    assign w_mag = r_dot[AccW-1] ? (~r_dot + AccW'(1)) : r_dot;
    assign w_den = r_prod[AccW-1:0];

    cossim_csub u_csub (
        .i_minuend    (w_cs_a),
        .i_subtrahend (w_cs_b),
        .o_ge         (w_cs_ge),
        .o_diff       (w_cs_diff)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (w_in_acc) n_state = S_MUL_AB;
            S_MUL_AB:   n_state = S_MUL_AA;
            S_MUL_AA:   n_state = S_MUL_BB;
            S_MUL_BB:   n_state = S_ACC_BB;
            S_ACC_BB:   n_state = r_last ? S_SQRT_A : S_IDLE;
            S_SQRT_A:   if (r_cnt == '0) n_state = S_SQRT_B;
            S_SQRT_B:   if (r_cnt == '0) n_state = S_MUL_DEN;
            S_MUL_DEN:  n_state = S_DIV_INIT;
            S_DIV_INIT: n_state = (r_prod[AccW-1:0] == '0) ? S_DONE : S_DIV;
            S_DIV:      if (r_cnt == '0) n_state = S_DONE;
            S_DONE:     if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // per-state operand selection
    always_comb begin
        o_s_tready = 1'b0;
        w_mul_x    = '0;
        w_mul_y    = '0;
        w_cs_a     = '0;
        w_cs_b     = '0;
        case (r_state)
            S_IDLE:    o_s_tready = 1'b1;
            S_MUL_AB: begin
                w_mul_x = MulW'(r_a);
                w_mul_y = MulW'(r_b);
            end
            S_MUL_AA: begin
                w_mul_x = MulW'(r_a);
                w_mul_y = MulW'(r_a);
            end
            S_MUL_BB: begin
                w_mul_x = MulW'(r_b);
                w_mul_y = MulW'(r_b);
            end
            S_MUL_DEN: begin
                w_mul_x = $signed({1'b0, r_ra});
                w_mul_y = $signed({1'b0, r_root[RootW-1:0]});
            end
            S_SQRT_A, S_SQRT_B: begin
                w_cs_a = {{(RemW-AccW){1'b0}}, r_rem[AccW-1:0]};
                w_cs_b = {{(RemW-AccW){1'b0}}, r_root + r_bit};
            end
            S_DIV_INIT: begin
                // quotient of 2^17 or more: mag >= 4 * den
                w_cs_a = {{(RemW-AccW){1'b0}}, w_mag};
                w_cs_b = {{(RemW-AccW-2){1'b0}}, w_den, 2'b00};
            end
            S_DIV: begin
                w_cs_a = r_rem;
                w_cs_b = r_dsh;
            end
            default: ;
        endcase
    end

    // saturating accumulate of the registered product
    always_comb begin
        w_dot_sum = SumW'(r_dot) + r_prod;
        if (r_state == S_MUL_BB)
            w_norm_old = $signed({{(SumW-AccW){1'b0}}, r_norm_a});
        else
            w_norm_old = $signed({{(SumW-AccW){1'b0}}, r_norm_b});
        w_norm_sum = w_norm_old + r_prod;
    end

    // root step and final clamp
    always_comb begin
        w_root_next = w_cs_ge ? ((r_root >> 1) + r_bit) : (r_root >> 1);
        if (r_zero)
            w_cos = '0;
        else if (r_neg)
            w_cos = (r_ovf || r_q > QNegLim) ? CosMin : CosW'(-r_q);
        else
            w_cos = (r_ovf || r_q > QPosLim) ? CosMax : r_q[CosW-1:0];
    end

    // sequencer, output valid and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_dot       <= '0;
            r_norm_a    <= '0;
            r_norm_b    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free)
                r_out_valid <= 1'b1;
            else if (r_out_valid && i_m_tready)
                r_out_valid <= 1'b0;
            case (r_state)
                S_MUL_AA: begin
                    if (w_dot_sum > DotMax)      r_dot <= DotMax[AccW-1:0];
                    else if (w_dot_sum < DotMin) r_dot <= DotMin[AccW-1:0];
                    else                         r_dot <= w_dot_sum[AccW-1:0];
                end
                S_MUL_BB: r_norm_a <= (w_norm_sum > NormMax) ? NormMax[AccW-1:0]
                                                             : w_norm_sum[AccW-1:0];
                S_ACC_BB: r_norm_b <= (w_norm_sum > NormMax) ? NormMax[AccW-1:0]
                                                             : w_norm_sum[AccW-1:0];
                S_DONE: begin
                    if (w_out_free) begin
                        r_dot       <= '0;
                        r_norm_a    <= '0;
                        r_norm_b    <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a    <= i_s_tdata[ElemW-1:0];
            r_b    <= i_s_tdata[2*ElemW-1:ElemW];
            r_last <= i_s_tlast;
        end
        if (r_state == S_MUL_AB || r_state == S_MUL_AA || r_state == S_MUL_BB ||
            r_state == S_MUL_DEN)
            r_prod <= w_mul_x * w_mul_y;
        case (r_state)
            S_ACC_BB: begin
                r_rem  <= {{(RemW-AccW){1'b0}}, r_norm_a};
                r_root <= '0;
                r_bit  <= SqrtBit0;
                r_cnt  <= SqrtLast;
            end
            S_SQRT_A: begin
                if (r_cnt == '0) begin
                    // root of norm a done, start on norm b
                    r_ra   <= w_root_next[RootW-1:0];
                    r_rem  <= {{(RemW-AccW){1'b0}}, r_norm_b};
                    r_root <= '0;
                    r_bit  <= SqrtBit0;
                    r_cnt  <= SqrtLast;
                end else begin
                    if (w_cs_ge) r_rem <= w_cs_diff;
                    r_root <= w_root_next;
                    r_bit  <= r_bit >> 2;
                    r_cnt  <= r_cnt - CntW'(1);
                end
            end
            S_SQRT_B: begin
                if (w_cs_ge) r_rem <= w_cs_diff;
                r_root <= w_root_next;
                r_bit  <= r_bit >> 2;
                r_cnt  <= r_cnt - CntW'(1);
            end
            S_DIV_INIT: begin
                r_zero <= (w_den == '0);
                r_neg  <= r_dot[AccW-1];
                r_ovf  <= w_cs_ge;
                r_rem  <= {1'b0, w_mag, {FracBits{1'b0}}};
                r_dsh  <= {w_den, {(RemW-AccW){1'b0}}};
                r_q    <= '0;
                r_cnt  <= DivLast;
            end
            S_DIV: begin
                if (w_cs_ge) r_rem <= w_cs_diff;
                r_q   <= {r_q[QuoW-2:0], w_cs_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - CntW'(1);
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_cos  <= w_cos;
                    r_out_zero <= r_zero;
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_cos;
    assign o_m_tuser  = r_out_zero;

endmodule
`default_nettype wire

[rtl/core/cossim_csub.sv]
// Shared compare-subtract unit used by the square root and the divider.
`timescale 1ns / 1ps
`default_nettype none
module cossim_csub (
    input  wire logic [cossim_pkg::RemW-1:0] i_minuend,
    input  wire logic [cossim_pkg::RemW-1:0] i_subtrahend,
    output logic                             o_ge,
    output logic [cossim_pkg::RemW-1:0]      o_diff
);
    import cossim_pkg::*;

    logic [RemW:0] w_diff;

    // one wide subtract; the borrow tells the compare
    always_comb begin
        w_diff = {1'b0, i_minuend} - {1'b0, i_subtrahend};
        o_ge   = ~w_diff[RemW];
        o_diff = w_diff[RemW-1:0];
    end

endmodule
`default_nettype wire

[rtl/core/cossim_chk.sv]
// Port-level checker for the cosine similarity block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cossim_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] o_m_tdata,
    input wire logic        o_m_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    // zero norm always reports a zero cosine
    a_zero_cos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == 16'h0000)
        else $error("zero norm with nonzero cosine");

    // an accepted beat keeps the block busy for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready right after accepting a beat");

    // reset leaves no result pending and the input side open
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("state after reset wrong");

endmodule

bind cosine_similarity cossim_chk u_cossim_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the streaming cosine similarity block.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import cossim_pkg::*;

    // run limit for about 1200 pairs
    localparam int CycleLimit = 500_000;
    localparam int MaxShown   = 10;
    localparam int DrainWait  = 100;

    // one expected cosine beat
    typedef struct packed {
        logic [CosW-1:0] cosine;
        logic            zero_norm;
    } t_cos_result;

    // element choice for a random vector
    typedef enum int {
        VEC_MIXED,
        VEC_A_ZERO,
        VEC_B_ZERO
    } t_vec_kind;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [31:0] i_s_tdata  = '0;   // [15:0] elem_a, [31:16] elem_b
    logic        i_s_tlast  = 1'b0; // last_elem
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;         // [15:0] cosine
    logic        o_m_tuser;         // [0] zero_norm

    // predictor state and expected cosines
    longint      dot_acc;
    longint      norm_a_acc;
    longint      norm_b_acc;
    t_cos_result cosine_q[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    longint      cycle_count    = 0;

    cosine_similarity u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MaxShown) $display("%s", msg);
    endtask

    // floor square root, one result bit per step
    function automatic bit [RootW-1:0] floor_sqrt(input bit [AccW-1:0] x);
        bit [63:0] rem;
        bit [63:0] root;
        bit [63:0] probe;
        rem   = 64'(x);
        root  = '0;
        probe = 64'd1 << (AccW - 2);
        while (probe > rem) probe >>= 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root[RootW-1:0];
    endfunction

    // accumulate one accepted pair; on the last pair queue the cosine and clear
    task automatic accumulate_pair(input logic signed [ElemW-1:0] a,
                                   input logic signed [ElemW-1:0] b,
                                   input logic is_last);
        t_cos_result      res;
        bit [RootW-1:0]   root_a;
        bit [RootW-1:0]   root_b;
        bit [63:0]        den;
        bit [63:0]        mag;
        bit [63:0]        quo;
        dot_acc    = dot_acc + longint'(a) * longint'(b);
        norm_a_acc = norm_a_acc + longint'(a) * longint'(a);
        norm_b_acc = norm_b_acc + longint'(b) * longint'(b);
        if (dot_acc > DotMax) dot_acc = DotMax;
        else if (dot_acc < DotMin) dot_acc = DotMin;
        if (norm_a_acc > NormMax) norm_a_acc = NormMax;
        if (norm_b_acc > NormMax) norm_b_acc = NormMax;
        if (!is_last) return;

        root_a = floor_sqrt(norm_a_acc[AccW-1:0]);
        root_b = floor_sqrt(norm_b_acc[AccW-1:0]);
        den    = 64'(root_a) * 64'(root_b);
        if (den == 0) begin
            res.cosine    = '0;
            res.zero_norm = 1'b1;
        end else begin
            mag = (dot_acc < 0) ? 64'(-dot_acc) : 64'(dot_acc);
            quo = (mag << FracBits) / den;
            // floor roots can push the ratio past one: clamp both sides
            if (dot_acc < 0)
                res.cosine = (quo > 64'(QNegLim)) ? CosMin : 16'(-quo);
            else
                res.cosine = (quo > 64'(QPosLim)) ? CosMax : 16'(quo);
            res.zero_norm = 1'b0;
        end
        cosine_q.insert(cosine_q.size(), res);
        dot_acc    = 0;
        norm_a_acc = 0;
        norm_b_acc = 0;
    endtask

    // send one element pair, with a random idle gap ahead of it
    task automatic send_pair(input logic signed [ElemW-1:0] a,
                             input logic signed [ElemW-1:0] b,
                             input logic is_last);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {b, a};
        i_s_tlast  <= is_last;
        do @(posedge i_clk); while (!o_s_tready);
        accumulate_pair(a, b, is_last);
    endtask

    // drop valid and hold off until every queued cosine has come back
    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (cosine_q.size() != 0) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_cos_result exp_res;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (cosine_q.size() == 0) begin
                flag_error($sformatf("unexpected beat: cosine %0d zero_norm %0b",
                                     $signed(o_m_tdata), o_m_tuser));
            end else begin
                exp_res = cosine_q.pop_front();
                if (o_m_tdata !== exp_res.cosine || o_m_tuser !== exp_res.zero_norm)
                    flag_error($sformatf(
                        "mismatch: cosine exp %0d got %0d, zero_norm exp %0b got %0b",
                        $signed(exp_res.cosine), $signed(o_m_tdata),
                        exp_res.zero_norm, o_m_tuser));
            end
        end
    end

    // random element, biased toward the ends of the range and small values around zero
    function automatic logic signed [ElemW-1:0] pick_elem();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3, 4:    return 16'($urandom_range(16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // extremes, zero norms, clamping on both sides and bit patterns
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh7FFF, 1'b1);
        send_pair(16'sh0000, 16'sh0000, 1'b1);
        send_pair(16'sh0000, 16'sh8000, 1'b1);
        send_pair(16'sd12345, 16'sh0000, 1'b1);
        // ratio above one after the floor roots
        send_pair(16'sd1, 16'sd1, 1'b0);
        send_pair(16'sd1, 16'sd1, 1'b1);
        send_pair(16'sd1, 16'sd1, 1'b0);
        send_pair(-16'sd1, -16'sd1, 1'b1);
        // orthogonal, then opposite bit patterns
        send_pair(16'sd1, 16'sd1, 1'b0);
        send_pair(16'sd1, -16'sd1, 1'b1);
        send_pair(16'sh5555, 16'shAAAA, 1'b0);
        send_pair(16'shAAAA, 16'sh5555, 1'b1);
        // zero norm over two pairs, then a three-pair vector
        send_pair(16'sh0000, 16'sd7, 1'b0);
        send_pair(16'sh0000, -16'sd3, 1'b1);
        send_pair(16'sd30000, -16'sd20000, 1'b0);
        send_pair(-16'sd1, 16'sd2, 1'b0);
        send_pair(16'sd100, 16'sd100, 1'b1);
        hold_until_drained();
    endtask

    // random vectors, mostly short, under one idling and stall setting
    task automatic test_random(input int unsigned idle_pct,
                               input int unsigned stall_pct,
                               input int unsigned n_items);
        int unsigned sent;
        int unsigned vec_len;
        t_vec_kind   kind;
        logic signed [ElemW-1:0] a;
        logic signed [ElemW-1:0] b;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            vec_len = ($urandom_range(9) == 0) ? $urandom_range(1, 48)
                                               : $urandom_range(1, 12);
            case ($urandom_range(11))
                0:       kind = VEC_A_ZERO;
                1:       kind = VEC_B_ZERO;
                default: kind = VEC_MIXED;
            endcase
            for (int i = 0; i < vec_len; i++) begin
                a = (kind == VEC_A_ZERO) ? '0 : pick_elem();
                b = (kind == VEC_B_ZERO) ? '0 : pick_elem();
                send_pair(a, b, i == vec_len - 1);
                sent++;
            end
        end
        hold_until_drained();
    endtask

    // sequence of tests
    initial begin
        dot_acc    = 0;
        norm_a_acc = 0;
        norm_b_acc = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(0, 0, 300);
        test_random(72, 0, 300);
        test_random(0, 72, 300);
        test_random(25, 25, 300);

        repeat (DrainWait) @(posedge i_clk);
        if (cosine_q.size() != 0)
            flag_error($sformatf("%0d cosine beats never arrived", cosine_q.size()));
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire

[files.f]
rtl/core/cossim_pkg.sv
rtl/core/cossim_csub.sv
rtl/core/cosine_similarity.sv
rtl/core/cossim_chk.sv
bench/tb.sv
